### rtl/core/qte_pkg.sv
package qte_pkg;

  // Output angle format and CORDIC length
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 20;

  // Internal widths
  localparam int VEC_W = 40;  // CORDIC x/y vectors, q30
  localparam int ANG_W = 34;  // CORDIC angle, q30 radians
  localparam int DEG_W = 27;  // signed degrees, ANGLE_FRAC_BITS fraction
  localparam int SQ_W  = 62;  // square root radicand and partial root

  localparam int SQRT_STAGES = 31;  // one result bit per stage, radicand <= 2^60

  localparam logic signed [VEC_W-1:0] ONE_VEC     = VEC_W'(64'sd1073741824);
  localparam logic signed [ANG_W-1:0] HALF_PI_ANG = ANG_W'(64'sd1686629713);

  // rad -> deg: r * 573 / (5 * 2^RD_SHIFT), round half away from zero
  localparam int          RD_SHIFT = 31 - ANGLE_FRAC_BITS;
  localparam int          RD_M_W   = ANG_W + 10;
  localparam int          RD_T_W   = RD_M_W - RD_SHIFT;
  localparam logic [RD_M_W-1:0] RD_HALF = RD_M_W'((64'd5 << RD_SHIFT) / 2);
  localparam logic [31:0] RD_RECIP = 32'hCCCC_CCCD;  // ceil(2^34 / 5)
  localparam int          RD_RSH   = 34;

  localparam logic [30:0] ATAN_TAB [0:29] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
    31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536,
    31'd32768, 31'd16384, 31'd8192, 31'd4096, 31'd2048,
    31'd1024, 31'd512, 31'd256, 31'd128, 31'd64,
    31'd32, 31'd16, 31'd8, 31'd4, 31'd2
  };

endpackage

### rtl/core/qte_isqrt.sv
module qte_isqrt import qte_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [SQ_W-1:0] rad_i,
  output logic            valid_o,
  output logic [30:0]     root_o
);

  logic [SQRT_STAGES-1:0] vld_q;
  logic [SQ_W-1:0]        rem_q  [SQRT_STAGES];
  logic [SQ_W-1:0]        root_q [SQRT_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SQRT_STAGES-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STAGES - 1 - k));
    logic [SQ_W-1:0] rem_in, root_in, trial, rem_d, root_d;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      trial = root_in + BIT;
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + BIT;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
    end
  end

  assign valid_o = vld_q[SQRT_STAGES-1];
  assign root_o  = root_q[SQRT_STAGES-1][30:0];

endmodule

### rtl/core/qte_cordic.sv
module qte_cordic import qte_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [VEC_W-1:0] y_i,
  input  logic signed [VEC_W-1:0] x_i,
  output logic                    valid_o,
  output logic signed [DEG_W-1:0] deg_o
);

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;
  } vec_t;

  logic [CORDIC_STEPS:0] vld_q;
  vec_t                  st_q [CORDIC_STEPS+1];
  vec_t                  pre_d;

  // quadrant fold into the right half plane
  always_comb begin
    pre_d.zero = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        pre_d.x = y_i;
        pre_d.y = -x_i;
        pre_d.z = HALF_PI_ANG;
      end else begin
        pre_d.x = -y_i;
        pre_d.y = x_i;
        pre_d.z = -HALF_PI_ANG;
      end
    end else begin
      pre_d.x = x_i;
      pre_d.y = y_i;
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= pre_d;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [VEC_W-1:0] dx, dy;
    logic signed [ANG_W-1:0] da;
    vec_t                    nx_d;

    always_comb begin
      dx      = st_q[i].y >>> i;
      dy      = st_q[i].x >>> i;
      da      = ANG_W'(ATAN_TAB[i]);
      nx_d    = st_q[i];
      if (st_q[i].y >= 0) begin
        nx_d.x = st_q[i].x + dx;
        nx_d.y = st_q[i].y - dy;
        nx_d.z = st_q[i].z + da;
      end else begin
        nx_d.x = st_q[i].x - dx;
        nx_d.y = st_q[i].y + dy;
        nx_d.z = st_q[i].z - da;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[i+1] <= nx_d;
    end
  end

  // radians to degrees, three stages
  logic signed [ANG_W-1:0]      ang;
  logic [ANG_W-1:0]             mag_d;
  logic [RD_M_W-1:0]            m_q;
  logic                         neg_a_q, neg_b_q;
  logic [RD_T_W-1:0]            t_d;
  logic [RD_T_W+31:0]           p_q;
  logic [RD_T_W+31-RD_RSH:0]    quo;
  logic signed [DEG_W-1:0]      deg_d, deg_q;
  logic [2:0]                   rd_vld_q;

  always_comb begin
    ang   = st_q[CORDIC_STEPS].zero ? '0 : st_q[CORDIC_STEPS].z;
    mag_d = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
    t_d   = RD_T_W'((m_q + RD_HALF) >> RD_SHIFT);
    quo   = p_q[RD_T_W+31:RD_RSH];
    deg_d = neg_b_q ? -DEG_W'(quo) : DEG_W'(quo);
  end

  always_ff @(posedge clk_i) begin
    m_q     <= RD_M_W'(mag_d) * RD_M_W'(10'd573);
    neg_a_q <= ang[ANG_W-1];
    p_q     <= (RD_T_W+32)'(t_d) * (RD_T_W+32)'(RD_RECIP);
    neg_b_q <= neg_a_q;
    deg_q   <= deg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= '0;
    end else begin
      vld_q    <= {vld_q[CORDIC_STEPS-1:0], valid_i};
      rd_vld_q <= {rd_vld_q[1:0], vld_q[CORDIC_STEPS]};
    end
  end

  assign valid_o = rd_vld_q[2];
  assign deg_o   = deg_q;

endmodule

### rtl/core/quaternion_to_euler_degrees_top.sv
// Throughput: one quaternion per clock; busy is low except right after reset.
// The depth is set by the 31-stage square root for pitch and the 20-stage CORDIC.
// Reset (rst_ni low, asynchronous) drops every in-flight transaction.
// Results cannot be held off: each is shown for one cycle with done_o.
module quaternion_to_euler_degrees_top import qte_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] quat_w_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  output logic               done_o,
  output logic signed [23:0] pitch_deg_o,
  output logic signed [24:0] roll_deg_o,
  output logic        [24:0] yaw_deg_o
);

  localparam int LATENCY = 5 + SQRT_STAGES + CORDIC_STEPS + 4;
  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << 60;
  localparam logic signed [DEG_W:0] HALF_TURN = (DEG_W+1)'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [DEG_W:0] FULL_TURN = (DEG_W+1)'(360 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [31:0]      s;
    logic signed [VEC_W-1:0] ry;
    logic signed [VEC_W-1:0] rx;
    logic signed [VEC_W-1:0] yy;
    logic signed [VEC_W-1:0] yx;
  } side_t;

  logic busy_q, accept;
  logic v1_q, v2_q, v3_q, v4_q;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // stage 1: ten exact products
  logic signed [63:0] ww_q, xx_q, yy_q, zz_q, wy_q, xz_q, yz_q, wx_q, xy_q, wz_q;

  always_ff @(posedge clk_i) begin
    ww_q <= quat_w_i * quat_w_i;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    wy_q <= quat_w_i * quat_y_i;
    xz_q <= quat_x_i * quat_z_i;
    yz_q <= quat_y_i * quat_z_i;
    wx_q <= quat_w_i * quat_x_i;
    xy_q <= quat_x_i * quat_y_i;
    wz_q <= quat_w_i * quat_z_i;
  end

  // stage 2: sums, q30 by floor shift (dropping the low 30 bits)
  logic signed [VEC_W-1:0] e_ww, e_xx, e_yy, e_zz, e_wy, e_xz, e_yz, e_wx, e_xy, e_wz;
  logic signed [VEC_W-1:0] s2_q;
  side_t                   side2_d, side2_q;

  always_comb begin
    e_ww = VEC_W'($signed(ww_q[63:30]));
    e_xx = VEC_W'($signed(xx_q[63:30]));
    e_yy = VEC_W'($signed(yy_q[63:30]));
    e_zz = VEC_W'($signed(zz_q[63:30]));
    e_wy = VEC_W'($signed(wy_q[63:30]));
    e_xz = VEC_W'($signed(xz_q[63:30]));
    e_yz = VEC_W'($signed(yz_q[63:30]));
    e_wx = VEC_W'($signed(wx_q[63:30]));
    e_xy = VEC_W'($signed(xy_q[63:30]));
    e_wz = VEC_W'($signed(wz_q[63:30]));
    side2_d.s  = '0;
    side2_d.ry = (e_yz + e_wx) <<< 1;
    side2_d.rx = ONE_VEC - ((e_xx + e_yy) <<< 1);
    side2_d.yy = (e_xy + e_wz) <<< 1;
    side2_d.yx = e_ww + e_xx - e_yy - e_zz;
  end

  always_ff @(posedge clk_i) begin
    s2_q    <= (e_wy - e_xz) <<< 1;
    side2_q <= side2_d;
  end

  // stage 3: clamp the asin argument to [-1, 1]
  side_t side3_d, side3_q;

  always_comb begin
    side3_d = side2_q;
    if (s2_q > ONE_VEC) begin
      side3_d.s = 32'(ONE_VEC);
    end else if (s2_q < -ONE_VEC) begin
      side3_d.s = 32'(-ONE_VEC);
    end else begin
      side3_d.s = 32'(s2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side3_d;
  end

  // stage 4: radicand 1 - s^2 in q60
  logic signed [63:0] sq;
  logic [SQ_W-1:0]    rad_q;
  side_t              side4_q;

  assign sq = side3_q.s * side3_q.s;

  always_ff @(posedge clk_i) begin
    rad_q   <= ONE_SQ - SQ_W'(sq);
    side4_q <= side3_q;
  end

  // square root, side data delayed to match
  logic        sq_vld;
  logic [30:0] root;
  side_t       side_dly_q [SQRT_STAGES];

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .rad_i   (rad_q),
    .valid_o (sq_vld),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    side_dly_q[0] <= side4_q;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      side_dly_q[k] <= side_dly_q[k-1];
    end
  end

  side_t side_al;
  assign side_al = side_dly_q[SQRT_STAGES-1];

  // three angle units side by side
  logic                    pitch_vld, roll_vld, yaw_vld;
  logic signed [DEG_W-1:0] pitch_deg, roll_deg, yaw_deg;

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .y_i     (VEC_W'(side_al.s)),
    .x_i     (VEC_W'({1'b0, root})),
    .valid_o (pitch_vld),
    .deg_o   (pitch_deg)
  );

  qte_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .y_i     (side_al.ry),
    .x_i     (side_al.rx),
    .valid_o (roll_vld),
    .deg_o   (roll_deg)
  );

  qte_cordic u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .y_i     (side_al.yy),
    .x_i     (side_al.yx),
    .valid_o (yaw_vld),
    .deg_o   (yaw_deg)
  );

  // output stage: yaw offset, wrap and floor at zero
  logic signed [DEG_W:0] yaw_off, yaw_d;
  logic signed [23:0]    pitch_q;
  logic signed [24:0]    roll_q;
  logic        [24:0]    yaw_q;
  logic                  done_q;

  always_comb begin
    yaw_off = (DEG_W+1)'(yaw_deg) + HALF_TURN;
    yaw_d   = yaw_off;
    if (yaw_off > FULL_TURN) begin
      yaw_d = yaw_off - FULL_TURN;
    end
    if (yaw_d < 0) begin
      yaw_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q <= pitch_deg[23:0];
    roll_q  <= roll_deg[24:0];
    yaw_q   <= yaw_d[24:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= pitch_vld && roll_vld && yaw_vld;
    end
  end

  assign done_o      = done_q;
  assign pitch_deg_o = pitch_q;
  assign roll_deg_o  = roll_q;
  assign yaw_deg_o   = yaw_q;

  // a result only ever follows an accepted transaction by the fixed latency
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without matching transaction");

  // the three angle units stay in lockstep
  a_units_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pitch_vld == roll_vld) && (roll_vld == yaw_vld))
    else $error("angle units out of step");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (yaw_deg_o <= 25'(360 << ANGLE_FRAC_BITS)))
    else $error("yaw above full turn");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((pitch_deg_o <= 24'sd5963776) && (pitch_deg_o >= -24'sd5963776)))
    else $error("pitch beyond quarter turn");

endmodule

### bench/euler_checker.sv
`timescale 1ns / 100ps

module euler_checker import qte_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] quat_w_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  input  logic               done_o,
  input  logic signed [23:0] pitch_deg_o,
  input  logic signed [24:0] roll_deg_o,
  input  logic        [24:0] yaw_deg_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [23:0] pitch;
    logic [24:0] roll;
    logic [24:0] yaw;
  } angles_t;

  angles_t angles_q[$];

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return floor_sh(a * b, 30);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, bitv;
    r = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >>> 1) + bitv;
      end else begin
        r = r >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return r;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(HALF_PI_ANG);
      end else begin
        t = x; x = -y; y = t; z = -longint'(HALF_PI_ANG);
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint to_degrees(longint r);
    longint m, d, q;
    m = (r < 0 ? -r : r) * 573;
    d = 64'sd10 <<< (30 - ANGLE_FRAC_BITS);
    q = (m + d / 2) / d;
    return r < 0 ? -q : q;
  endfunction

  function automatic angles_t euler_of(longint w, longint x, longint y, longint z);
    longint one, s, c, p, r, yw, full;
    angles_t a;
    one = 64'sd1073741824;
    full = 64'sd360 <<< ANGLE_FRAC_BITS;
    s = 2 * (qmul(w, y) - qmul(x, z));
    if (s > one) s = one;
    if (s < -one) s = -one;
    c = int_sqrt(one * one - s * s);
    p = to_degrees(vec_angle(s, c));
    r = to_degrees(vec_angle(2 * (qmul(y, z) + qmul(w, x)),
                             one - 2 * (qmul(x, x) + qmul(y, y))));
    yw = to_degrees(vec_angle(2 * (qmul(x, y) + qmul(w, z)),
                              qmul(w, w) + qmul(x, x) - qmul(y, y) - qmul(z, z)));
    yw += 64'sd180 <<< ANGLE_FRAC_BITS;
    if (yw > full) yw -= full;
    if (yw < 0) yw = 0;
    a.pitch = p[23:0];
    a.roll  = r[24:0];
    a.yaw   = yw[24:0];
    return a;
  endfunction

  assign pending_o = angles_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    angles_t e;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (start && !busy)
        angles_q.push_back(euler_of(quat_w_i, quat_x_i, quat_y_i, quat_z_i));
      if (done_o) begin
        if (angles_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result at %0t", $time);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = angles_q.pop_front();
          if (e.pitch !== pitch_deg_o || e.roll !== roll_deg_o || e.yaw !== yaw_deg_o) begin
            if (fail_count_o < 10)
              $display("angle mismatch: exp p=%h r=%h y=%h got p=%h r=%h y=%h",
                       e.pitch, e.roll, e.yaw, pitch_deg_o, roll_deg_o, yaw_deg_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY = 60;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i, rst_ni, start, busy, done_o;
  logic signed [31:0] quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic signed [23:0] pitch_deg_o;
  logic signed [24:0] roll_deg_o;
  logic        [24:0] yaw_deg_o;
  int fail_count, pending, idle_cycles;
  logic [31:0] q0, q1, q2, q3;

  quaternion_to_euler_degrees_top i_dut (.*);

  euler_checker i_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    if (k < 9) return $urandom_range(0, 2000) - 1000;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_edge(int k);
    case (k % 6)
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return 32'h0;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return 32'h2D41_3CCD; // ~1/sqrt2
    endcase
  endfunction

  task automatic send(input logic [31:0] w, x, y, z);
    int gap;
    start    <= 1'b1;
    quat_w_i <= w;
    quat_x_i <= x;
    quat_y_i <= y;
    quat_z_i <= z;
    do @(posedge clk_i); while (busy);
    gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 19) == 0) ?
          $urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    idle_cycles = 0;
    rst_ni   = 1'b0;
    start    = 1'b0;
    quat_w_i = '0;
    quat_x_i = '0;
    quat_y_i = '0;
    quat_z_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: identity, axis turns, saturation, zero quaternion, extremes
    send(32'h4000_0000, 0, 0, 0);
    send(0, 0, 0, 0);
    send(0, 32'h4000_0000, 0, 0);
    send(0, 0, 32'h4000_0000, 0);
    send(0, 0, 0, 32'h4000_0000);
    send(32'hC000_0000, 0, 0, 0);
    send(32'h4000_0000, 0, 32'h4000_0000, 0);
    send(32'h4000_0000, 0, 32'hC000_0000, 0);
    send(32'h2D41_3CCD, 0, 0, 32'h2D41_3CCD);
    send(32'h2D41_3CCD, 0, 0, 32'hD2BE_C333);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send(0, 32'hC000_0000, 0, 1);
    send(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000);
    // hold off until the pipe drains
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    for (int n = 0; n < 1250; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        q0 = pick_edge($urandom); q1 = pick_edge($urandom);
        q2 = pick_edge($urandom); q3 = pick_edge($urandom);
      end else begin
        q0 = rand_comp(); q1 = rand_comp(); q2 = rand_comp(); q3 = rand_comp();
      end
      send(q0, q1, q2, q3);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
